// ===== design/aec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aec_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 38;
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int DTIME_W    = 14;
    localparam int HOLD_W     = 8;

    localparam logic [15:0] DRIVE_FLOOR = 16'd2048;

    typedef enum logic [2:0] {
        REG_EFFECT_ENABLES = 3'd0,
        REG_DRIVE_AMOUNT   = 3'd1,
        REG_MOD_ROUTING    = 3'd2,
        REG_CRUSH_SHIFT    = 3'd3,
        REG_XOR_MASK       = 3'd4,
        REG_DELAY_TIME     = 3'd5,
        REG_DELAY_FEEDBACK = 3'd6,
        REG_MASTER_VOLUME  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_LFO1 = 3'd1,
        SRC_LFO2 = 3'd2,
        SRC_ENV1 = 3'd3,
        SRC_ENV2 = 3'd4
    } mod_src_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_count;
        logic              interp_on;
        logic              delay_on;
        logic              drive_on;
    } enables_t;

    typedef struct packed {
        logic [15:0] vol_depth;
        logic [2:0]  vol_src;
        logic [15:0] drive_depth;
        logic [2:0]  drive_src;
    } mod_routing_t;

    typedef struct packed {
        enables_t           effect_enables;
        logic [15:0]        drive_amount;
        mod_routing_t       mod_routing;
        logic [3:0]         crush_shift;
        logic [15:0]        xor_mask;
        logic [DTIME_W-1:0] delay_time;
        logic [15:0]        delay_feedback;
        logic [15:0]        master_volume;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        effect_enables: '{hold_count: '0, interp_on: 1'b1, delay_on: 1'b0, drive_on: 1'b0},
        drive_amount:   16'd0,
        mod_routing:    '0,
        crush_shift:    4'd0,
        xor_mask:       16'd0,
        delay_time:     '0,
        delay_feedback: 16'd0,
        master_volume:  16'hFFFF
    };

    typedef struct packed {
        logic calc_quot;
        logic calc_rem;
        logic calc_addr;
        logic rd_en;
        logic commit;
    } dly_ctrl_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] level;
    } mod_pick_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRIVE_SCALE,
        ST_DRIVE_MOD,
        ST_DRIVE_SQUARE,
        ST_DRIVE_APPLY,
        ST_VOL_MOD,
        ST_CRUSH,
        ST_DELAY_MIX,
        ST_MASTER,
        ST_DONE
    } state_t;

    function automatic mod_pick_t pick_level(
        input logic [2:0]  src,
        input logic [15:0] lfo1,
        input logic [15:0] lfo2,
        input logic [15:0] env1,
        input logic [15:0] env2
    );
        mod_pick_t p;
        p.hit   = 1'b1;
        p.level = 16'd0;
        unique case (mod_src_t'(src))
            SRC_LFO1: p.level = lfo1;
            SRC_LFO2: p.level = lfo2;
            SRC_ENV1: p.level = env1;
            SRC_ENV2: p.level = env2;
            default:  p.hit = 1'b0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/aec_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aec_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [aec_pkg::SAMPLE_W-1:0] in_sample;
    logic        [aec_pkg::LEVEL_W-1:0]  lfo1_level;
    logic        [aec_pkg::LEVEL_W-1:0]  lfo2_level;
    logic        [aec_pkg::LEVEL_W-1:0]  env1_level;
    logic        [aec_pkg::LEVEL_W-1:0]  env2_level;

    modport source (
        output valid, in_sample, lfo1_level, lfo2_level, env1_level, env2_level,
        input  ready
    );
    modport sink (
        input  valid, in_sample, lfo1_level, lfo2_level, env1_level, env2_level,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/aec_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aec_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [aec_pkg::SAMPLE_W-1:0] out_sample;

    modport source (output valid, out_sample, input ready);
    modport sink (input valid, out_sample, output ready);
endinterface

`default_nettype wire

// ===== design/aec_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aec_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aec_pkg::CFG_IDX_W-1:0]    index;
    logic [aec_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/audio_effects_chain.sv =====
// The sequencer steps each sample through the chain of multiplications in registered stages
// and offers the result transaction from the output register; a new sample is accepted only
// in idle, after the previous result has been loaded into that register.
// Reset clears the configuration to its defaults, the previous output, the delay write
// position and the hold count; delay entries not yet written read as zero, so the delay
// memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module audio_effects_chain #(
    parameter int DELAY_DEPTH = 16384
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    aec_sample_if.sink      sample_ch,
    aec_result_if.source    result_ch,
    aec_cfg_if.sink         cfg_ch
);

    aec_pkg::cfg_t        cfg;
    aec_pkg::dly_ctrl_t   dly_ctrl;
    logic [15:0]          dly_wdata;
    logic [15:0]          dly_rdata;

    aec_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    aec_delay_line #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_delay_line (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctrl  (dly_ctrl),
        .wdata (dly_wdata),
        .rdata (dly_rdata)
    );

    aec_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg       (cfg),
        .dly_ctrl  (dly_ctrl),
        .dly_wdata (dly_wdata),
        .dly_rdata (dly_rdata)
    );

endmodule

`default_nettype wire

// ===== design/aec_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aec_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    aec_cfg_if.sink           cfg_ch,
    output aec_pkg::cfg_t     cfg
);

    aec_pkg::cfg_t cfg_reg;

    assign cfg_ch.ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= aec_pkg::CFG_RESET;
        end
        else if (cfg_ch.valid && cfg_ch.ready) begin
            unique case (aec_pkg::reg_idx_t'(cfg_ch.index))
                aec_pkg::REG_EFFECT_ENABLES:
                    cfg_reg.effect_enables <= aec_pkg::enables_t'(cfg_ch.data[10:0]);
                aec_pkg::REG_DRIVE_AMOUNT:
                    cfg_reg.drive_amount <= cfg_ch.data[15:0];
                aec_pkg::REG_MOD_ROUTING:
                    cfg_reg.mod_routing <= aec_pkg::mod_routing_t'(cfg_ch.data[37:0]);
                aec_pkg::REG_CRUSH_SHIFT:
                    cfg_reg.crush_shift <= cfg_ch.data[3:0];
                aec_pkg::REG_XOR_MASK:
                    cfg_reg.xor_mask <= cfg_ch.data[15:0];
                aec_pkg::REG_DELAY_TIME:
                    cfg_reg.delay_time <= cfg_ch.data[aec_pkg::DTIME_W-1:0];
                aec_pkg::REG_DELAY_FEEDBACK:
                    cfg_reg.delay_feedback <= cfg_ch.data[15:0];
                aec_pkg::REG_MASTER_VOLUME:
                    cfg_reg.master_volume <= cfg_ch.data[15:0];
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/aec_delay_line.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aec_delay_line #(
    parameter int DELAY_DEPTH = 16384
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  aec_pkg::cfg_t          cfg,
    input  aec_pkg::dly_ctrl_t     ctrl,
    input  wire logic [15:0]       wdata,
    output logic [15:0]            rdata
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int SH    = aec_pkg::DTIME_W + AW;
    localparam int QW    = 5;
    localparam int PW    = SH + QW;
    localparam int RW    = AW + 8;
    localparam logic [15:0] RECIP = 16'((64'd1 << SH) / DELAY_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);

    logic [15:0]                 mem [DELAY_DEPTH];
    logic [15:0]                 rd_q_reg;
    logic                        hit_reg;
    logic [AW-1:0]               pos_reg;
    logic                        wrapped_reg;
    logic [aec_pkg::HOLD_W-1:0]  hold_reg;
    logic [PW-1:0]               quot_reg;
    logic [AW-1:0]               rem_reg;
    logic [AW-1:0]               addr_reg;

    logic [QW-1:0]               quot_est;
    logic [RW-1:0]               rem_wide;
    logic [RW-1:0]               rem_fix;
    logic [AW:0]                 addr_sum;
    logic [AW:0]                 addr_fix;
    logic                        we;

    always_comb begin
        quot_est = quot_reg[SH +: QW];
        rem_wide = RW'(cfg.delay_time) - RW'(quot_est) * RW'(DELAY_DEPTH);
        rem_fix  = (rem_wide >= RW'(DELAY_DEPTH)) ? rem_wide - RW'(DELAY_DEPTH) : rem_wide;
        addr_sum = {1'b0, pos_reg} + DEPTH_W - {1'b0, rem_reg};
        addr_fix = (addr_sum >= DEPTH_W) ? addr_sum - DEPTH_W : addr_sum;
        we       = ctrl.commit && (hold_reg == '0);
    end

    assign rdata = hit_reg ? rd_q_reg : 16'd0;

    always_ff @(posedge clk) begin
        if (ctrl.calc_quot) begin
            quot_reg <= PW'(cfg.delay_time) * PW'(RECIP);
        end
        if (ctrl.calc_rem) begin
            rem_reg <= rem_fix[AW-1:0];
        end
        if (ctrl.calc_addr) begin
            addr_reg <= addr_fix[AW-1:0];
        end
    end

    always_ff @(posedge clk) begin
        if (we) begin
            mem[pos_reg] <= wdata;
        end
        if (ctrl.rd_en) begin
            rd_q_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hit_reg     <= 1'b0;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            hold_reg    <= '0;
        end
        else begin
            if (ctrl.rd_en) begin
                hit_reg <= wrapped_reg || (addr_reg < pos_reg);
            end
            if (ctrl.commit) begin
                if (hold_reg != '0) begin
                    hold_reg <= hold_reg - 1'b1;
                end
                else begin
                    hold_reg <= cfg.effect_enables.hold_count;
                    if (pos_reg == LAST_POS) begin
                        pos_reg     <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/aec_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aec_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    aec_sample_if.sink           sample_ch,
    aec_result_if.source         result_ch,
    input  aec_pkg::cfg_t        cfg,
    output aec_pkg::dly_ctrl_t   dly_ctrl,
    output logic [15:0]          dly_wdata,
    input  wire logic [15:0]     dly_rdata
);

    aec_pkg::state_t      state_reg;
    aec_pkg::state_t      state_next;

    logic                 out_valid_reg;
    logic [15:0]          out_reg;
    logic [15:0]          last_reg;

    logic signed [15:0]   sample_reg;
    logic [15:0]          dlvl_reg;
    logic [15:0]          vlvl_reg;
    logic                 dmod_reg;
    logic                 vmod_reg;
    logic [31:0]          p1_reg;
    logic [31:0]          gp_reg;
    logic [31:0]          p2_reg;
    logic [31:0]          sq_reg;
    logic signed [32:0]   p4_reg;
    logic signed [15:0]   t1_reg;
    logic signed [32:0]   p5_reg;
    logic signed [32:0]   dprod_reg;
    logic [16:0]          x_reg;
    logic [16:0]          t4_reg;
    logic signed [33:0]   p8_reg;

    aec_pkg::mod_pick_t   dpick;
    aec_pkg::mod_pick_t   vpick;
    logic                 accept;
    logic                 load_out;
    logic [15:0]          drv;
    logic [15:0]          drv_sq;
    logic [15:0]          drv_fl;
    logic signed [32:0]   p4_adj;
    logic [21:0]          q1;
    logic [15:0]          t1_clip;
    logic [15:0]          t1;
    logic signed [32:0]   p5_adj;
    logic [15:0]          t2;
    logic [15:0]          t3;
    logic [16:0]          x;
    logic signed [32:0]   dprod_adj;
    logic [15:0]          dsc;
    logic [17:0]          sum1;
    logic [17:0]          sum1_adj;
    logic [16:0]          t4;
    logic [17:0]          sum2;
    logic [17:0]          sum2_adj;
    logic [16:0]          t5;
    logic signed [33:0]   p8_adj;
    logic [15:0]          result;

    assign accept    = sample_ch.valid && sample_ch.ready;
    assign load_out  = !out_valid_reg || result_ch.ready;

    assign sample_ch.ready      = (state_reg == aec_pkg::ST_IDLE);
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.out_sample = out_reg;

    always_comb begin
        dpick = aec_pkg::pick_level(cfg.mod_routing.drive_src, sample_ch.lfo1_level,
                                    sample_ch.lfo2_level, sample_ch.env1_level,
                                    sample_ch.env2_level);
        vpick = aec_pkg::pick_level(cfg.mod_routing.vol_src, sample_ch.lfo1_level,
                                    sample_ch.lfo2_level, sample_ch.env1_level,
                                    sample_ch.env2_level);

        drv    = dmod_reg ? p2_reg[31:16] : cfg.drive_amount;
        drv_sq = sq_reg[31:16];
        drv_fl = (drv_sq < aec_pkg::DRIVE_FLOOR) ? aec_pkg::DRIVE_FLOOR : drv_sq;

        p4_adj = p4_reg + (p4_reg[32] ? 33'sd2047 : 33'sd0);
        q1     = p4_adj[32:11];
        if ($signed(q1) > 22'sd32767) begin
            t1_clip = 16'h7FFF;
        end
        else if ($signed(q1) < -22'sd32768) begin
            t1_clip = 16'h8000;
        end
        else begin
            t1_clip = q1[15:0];
        end
        t1 = cfg.effect_enables.drive_on ? t1_clip : sample_reg;

        p5_adj = p5_reg + (p5_reg[32] ? 33'sd65535 : 33'sd0);
        t2     = vmod_reg ? p5_adj[31:16] : t1_reg;
        t3     = t2 & (16'hFFFF << cfg.crush_shift);
        x      = {t3[15], t3 ^ cfg.xor_mask};

        dprod_adj = dprod_reg + (dprod_reg[32] ? 33'sd65535 : 33'sd0);
        dsc       = dprod_adj[31:16];
        sum1      = {x_reg[16], x_reg} + {{2{dsc[15]}}, dsc};
        sum1_adj  = sum1 + {17'd0, sum1[17]};
        t4        = cfg.effect_enables.delay_on ? sum1_adj[17:1] : x_reg;

        sum2     = {t4_reg[16], t4_reg} + {{2{last_reg[15]}}, last_reg};
        sum2_adj = sum2 + {17'd0, sum2[17]};
        t5       = cfg.effect_enables.interp_on ? sum2_adj[17:1] : t4_reg;

        p8_adj = p8_reg + (p8_reg[33] ? 34'sd65535 : 34'sd0);
        result = p8_adj[31:16];
    end

    always_comb begin
        state_next         = state_reg;
        dly_ctrl.calc_quot = 1'b0;
        dly_ctrl.calc_rem  = 1'b0;
        dly_ctrl.calc_addr = 1'b0;
        dly_ctrl.rd_en     = 1'b0;
        dly_ctrl.commit    = 1'b0;
        dly_wdata          = t4[15:0];
        unique case (state_reg)
            aec_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = aec_pkg::ST_DRIVE_SCALE;
                end
            end
            aec_pkg::ST_DRIVE_SCALE: begin
                dly_ctrl.calc_quot = 1'b1;
                state_next         = aec_pkg::ST_DRIVE_MOD;
            end
            aec_pkg::ST_DRIVE_MOD: begin
                dly_ctrl.calc_rem = 1'b1;
                state_next        = aec_pkg::ST_DRIVE_SQUARE;
            end
            aec_pkg::ST_DRIVE_SQUARE: begin
                dly_ctrl.calc_addr = 1'b1;
                state_next         = aec_pkg::ST_DRIVE_APPLY;
            end
            aec_pkg::ST_DRIVE_APPLY: begin
                dly_ctrl.rd_en = 1'b1;
                state_next     = aec_pkg::ST_VOL_MOD;
            end
            aec_pkg::ST_VOL_MOD: begin
                state_next = aec_pkg::ST_CRUSH;
            end
            aec_pkg::ST_CRUSH: begin
                state_next = aec_pkg::ST_DELAY_MIX;
            end
            aec_pkg::ST_DELAY_MIX: begin
                dly_ctrl.commit = cfg.effect_enables.delay_on;
                state_next      = aec_pkg::ST_MASTER;
            end
            aec_pkg::ST_MASTER: begin
                state_next = aec_pkg::ST_DONE;
            end
            aec_pkg::ST_DONE: begin
                if (load_out) begin
                    state_next = aec_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aec_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= aec_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= 16'd0;
        end
        else begin
            state_reg <= state_next;
            if ((state_reg == aec_pkg::ST_DONE) && load_out) begin
                out_valid_reg <= 1'b1;
                last_reg      <= result;
            end
            else if (result_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            sample_reg <= sample_ch.in_sample;
            dlvl_reg   <= dpick.level;
            vlvl_reg   <= vpick.level;
            dmod_reg   <= dpick.hit;
            vmod_reg   <= vpick.hit;
        end
        unique case (state_reg)
            aec_pkg::ST_DRIVE_SCALE: begin
                p1_reg <= {16'd0, cfg.drive_amount} * {16'd0, cfg.mod_routing.drive_depth};
                gp_reg <= {16'd0, vlvl_reg} * {16'd0, cfg.mod_routing.vol_depth};
            end
            aec_pkg::ST_DRIVE_MOD: begin
                p2_reg <= {16'd0, p1_reg[31:16]} * {16'd0, dlvl_reg};
            end
            aec_pkg::ST_DRIVE_SQUARE: begin
                sq_reg <= {16'd0, drv} * {16'd0, drv};
            end
            aec_pkg::ST_DRIVE_APPLY: begin
                p4_reg <= sample_reg * $signed({1'b0, drv_fl});
            end
            aec_pkg::ST_VOL_MOD: begin
                t1_reg    <= t1;
                p5_reg    <= $signed(t1) * $signed({1'b0, gp_reg[31:16]});
                dprod_reg <= $signed(dly_rdata) * $signed({1'b0, cfg.delay_feedback});
            end
            aec_pkg::ST_CRUSH: begin
                x_reg <= x;
            end
            aec_pkg::ST_DELAY_MIX: begin
                t4_reg <= t4;
            end
            aec_pkg::ST_MASTER: begin
                p8_reg <= $signed(t5) * $signed({1'b0, cfg.master_volume});
            end
            aec_pkg::ST_DONE: begin
                if (load_out) begin
                    out_reg <= result;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== test/tb_audio_effects_chain.sv =====
`timescale 1ns / 1ps

module tb_audio_effects_chain;

    import aec_pkg::*;

    localparam int ECHO_DEPTH   = 16384;
    localparam int SAMPLE_GOAL  = 1600;
    localparam int QUIET_FROM   = 1450;
    localparam int REPORT_LIMIT = 20;

    localparam logic [2:0] SRC_UNUSED_LO = 3'd5;
    localparam logic [2:0] SRC_UNUSED_HI = 3'd7;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [15:0] in_sample;
        logic [15:0]        lfo1_level;
        logic [15:0]        lfo2_level;
        logic [15:0]        env1_level;
        logic [15:0]        env2_level;
    } sample_item_t;

    typedef struct {
        reg_idx_t    idx;
        logic [37:0] data;
    } reg_write_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        reg_idx_t           idx;
        logic [37:0]        data;
        sample_item_t       item;
        bit                 typed;
        logic signed [15:0] want;
    } script_row_t;

    logic clk;
    logic rst_n;

    aec_sample_if sample_ch ();
    aec_result_if result_ch ();
    aec_cfg_if    cfg_ch ();

    audio_effects_chain #(
        .DELAY_DEPTH(ECHO_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_ch(sample_ch),
        .result_ch(result_ch),
        .cfg_ch   (cfg_ch)
    );

    cfg_t               shadow;
    logic [15:0]        echo_mem [ECHO_DEPTH];
    int unsigned        echo_wr_pos;
    logic [7:0]         echo_hold;
    logic [15:0]        prev_out;

    logic signed [15:0] expected_out [$];
    script_row_t        script [$];

    int  errors;
    int  checked;
    int  sent;
    int  phases;
    int  writes;
    int  echo_items;
    bit  idling_on;
    bit  quiet;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint widen16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic bit select_level(input logic [2:0] src, input sample_item_t s,
                                        output logic [15:0] lvl);
        lvl = 16'd0;
        case (mod_src_t'(src))
            SRC_LFO1: lvl = s.lfo1_level;
            SRC_LFO2: lvl = s.lfo2_level;
            SRC_ENV1: lvl = s.env1_level;
            SRC_ENV2: lvl = s.env2_level;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void store_reg(input reg_idx_t idx, input logic [37:0] data);
        case (idx)
            REG_EFFECT_ENABLES: shadow.effect_enables = enables_t'(data[10:0]);
            REG_DRIVE_AMOUNT:   shadow.drive_amount = data[15:0];
            REG_MOD_ROUTING:    shadow.mod_routing = mod_routing_t'(data);
            REG_CRUSH_SHIFT:    shadow.crush_shift = data[3:0];
            REG_XOR_MASK:       shadow.xor_mask = data[15:0];
            REG_DELAY_TIME:     shadow.delay_time = data[13:0];
            REG_DELAY_FEEDBACK: shadow.delay_feedback = data[15:0];
            REG_MASTER_VOLUME:  shadow.master_volume = data[15:0];
            default: ;
        endcase
    endfunction

    // Runs one sample through the effect chain and advances the delay and history state.
    function automatic logic signed [15:0] run_chain(input sample_item_t s);
        longint      t;
        longint      d;
        longint      step_sz;
        longint      rem;
        u64_t        drive;
        u64_t        g;
        logic [15:0] lvl;
        int unsigned rd;
        t = longint'(s.in_sample);
        if (shadow.effect_enables.drive_on) begin
            drive = u64_t'(shadow.drive_amount);
            if (select_level(shadow.mod_routing.drive_src, s, lvl))
                drive = (((drive * u64_t'(shadow.mod_routing.drive_depth)) >> 16)
                         * u64_t'(lvl)) >> 16;
            drive = (drive * drive) >> 16;
            if (drive < u64_t'(DRIVE_FLOOR))
                drive = u64_t'(DRIVE_FLOOR);
            t = (t * longint'(drive)) / 2048;
            if (t < -32768)
                t = -32768;
            else if (t > 32767)
                t = 32767;
        end
        if (select_level(shadow.mod_routing.vol_src, s, lvl)) begin
            g = (u64_t'(lvl) * u64_t'(shadow.mod_routing.vol_depth)) >> 16;
            t = (t * longint'(g)) / 65536;
        end
        step_sz = longint'(1) << shadow.crush_shift;
        rem = ((t % step_sz) + step_sz) % step_sz;
        t = t - rem;
        t = t ^ longint'({48'd0, shadow.xor_mask});
        if (shadow.effect_enables.delay_on) begin
            echo_items++;
            rd = (echo_wr_pos + ECHO_DEPTH - (shadow.delay_time % ECHO_DEPTH)) % ECHO_DEPTH;
            d = widen16(echo_mem[rd]);
            d = (d * longint'({48'd0, shadow.delay_feedback})) / 65536;
            t = (t + d) / 2;
            if (echo_hold != 8'd0) begin
                echo_hold = echo_hold - 8'd1;
            end
            else begin
                echo_mem[echo_wr_pos] = t[15:0];
                echo_wr_pos = (echo_wr_pos + 1) % ECHO_DEPTH;
                echo_hold = shadow.effect_enables.hold_count;
            end
        end
        if (shadow.effect_enables.interp_on)
            t = (t + widen16(prev_out)) / 2;
        t = (t * longint'({48'd0, shadow.master_volume})) / 65536;
        prev_out = t[15:0];
        return t[15:0];
    endfunction

    function automatic logic [37:0] route(input logic [2:0] dsrc, input logic [15:0] ddep,
                                          input logic [2:0] vsrc, input logic [15:0] vdep);
        mod_routing_t r;
        r.drive_src   = dsrc;
        r.drive_depth = ddep;
        r.vol_src     = vsrc;
        r.vol_depth   = vdep;
        return r;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic sample_item_t make_item(input logic [15:0] smp, input logic [15:0] l1,
                                               input logic [15:0] l2, input logic [15:0] e1,
                                               input logic [15:0] e2);
        sample_item_t s;
        s.in_sample  = smp;
        s.lfo1_level = l1;
        s.lfo2_level = l2;
        s.env1_level = e1;
        s.env2_level = e2;
        return s;
    endfunction

    function automatic void add_write(input reg_idx_t idx, input logic [37:0] data);
        script_row_t row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.data  = data;
        row.item  = make_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        row.typed = 1'b0;
        row.want  = 16'sd0;
        script.push_back(row);
    endfunction

    function automatic void add_sample(input sample_item_t s, input bit typed,
                                       input logic signed [15:0] want);
        script_row_t row;
        row.kind  = ROW_SAMPLE;
        row.idx   = REG_EFFECT_ENABLES;
        row.data  = '0;
        row.item  = s;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic logic [37:0] random_reg_value(input reg_idx_t idx);
        logic [37:0] v;
        v = '0;
        case (idx)
            REG_EFFECT_ENABLES: begin
                v[2:0] = $urandom_range(0, 7);
                v[10:3] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom();
            end
            REG_DRIVE_AMOUNT:   v[15:0] = pick16();
            REG_MOD_ROUTING:    v = route($urandom_range(0, 7), pick16(),
                                          $urandom_range(0, 7), pick16());
            REG_CRUSH_SHIFT:    v[3:0] = $urandom_range(0, 15);
            REG_XOR_MASK:       v[15:0] = ($urandom_range(0, 1) == 0) ? 16'd0 : pick16();
            REG_DELAY_TIME: begin
                case ($urandom_range(0, 9))
                    0:       v[13:0] = 14'd16380;
                    1:       v[13:0] = 14'h3FFF;
                    2, 3:    v[13:0] = $urandom();
                    default: v[13:0] = $urandom_range(0, 31);
                endcase
            end
            REG_DELAY_FEEDBACK: v[15:0] = pick16();
            REG_MASTER_VOLUME:  v[15:0] = ($urandom_range(0, 1) == 0) ? 16'hFFFF : pick16();
            default: ;
        endcase
        return v;
    endfunction

    task automatic apply_writes(input reg_write_t list [$]);
        sample_ch.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        foreach (list[k])
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= list[k].idx;
            cfg_ch.data  <= list[k].data;
            @(posedge clk);
            while (cfg_ch.ready !== 1'b1)
                @(posedge clk);
            store_reg(list[k].idx, list[k].data);
            writes++;
        end
        cfg_ch.valid <= 1'b0;
        phases++;
    endtask

    task automatic push_sample(input sample_item_t s, input bit typed,
                               input logic signed [15:0] want);
        int                 gap;
        logic signed [15:0] pred;
        gap = 0;
        if (idling_on && !quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.in_sample  <= s.in_sample;
        sample_ch.lfo1_level <= s.lfo1_level;
        sample_ch.lfo2_level <= s.lfo2_level;
        sample_ch.env1_level <= s.env1_level;
        sample_ch.env2_level <= s.env2_level;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        pred = run_chain(s);
        expected_out.push_back(typed ? want : pred);
        sent++;
    endtask

    // Result side: checks every transaction and inserts random stall bursts.
    initial
    begin
        int                 stall_left;
        logic signed [15:0] want_v;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (expected_out.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected output transaction, expected none, actual %0d",
                                 $time, result_ch.out_sample);
                end
                else
                begin
                    want_v = expected_out.pop_front();
                    checked++;
                    if (result_ch.out_sample !== want_v)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                                     $time, want_v, result_ch.out_sample);
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (rst_n && idling_on && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            result_ch.ready <= (stall_left == 0);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Timeout at %0t with %0d results outstanding", $time, expected_out.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        reg_write_t   batch [$];
        reg_write_t   w;
        sample_item_t s;
        int           i;
        int           n;
        errors      = 0;
        checked     = 0;
        sent        = 0;
        phases      = 0;
        writes      = 0;
        echo_items  = 0;
        idling_on   = 1'b0;
        quiet       = 1'b0;
        shadow      = CFG_RESET;
        echo_wr_pos = 0;
        echo_hold   = 8'd0;
        prev_out    = 16'd0;
        foreach (echo_mem[k])
            echo_mem[k] = 16'd0;

        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.in_sample  <= 16'sd0;
        sample_ch.lfo1_level <= 16'd0;
        sample_ch.lfo2_level <= 16'd0;
        sample_ch.env1_level <= 16'd0;
        sample_ch.env2_level <= 16'd0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_EFFECT_ENABLES;
        cfg_ch.data          <= '0;

        add_sample(make_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd0);
        add_sample(make_item(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, 16'sd0);
        add_write(REG_MASTER_VOLUME, 38'd0);
        add_sample(make_item(16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000), 1'b1, 16'sd0);
        add_sample(make_item(16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF), 1'b1, 16'sd0);
        add_write(REG_MASTER_VOLUME, 38'hFFFF);
        add_write(REG_EFFECT_ENABLES, 38'd0);
        add_sample(make_item(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, -16'sd32767);
        add_sample(make_item(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd32766);
        add_sample(make_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd0);
        add_write(REG_EFFECT_ENABLES, 38'd1);
        add_write(REG_DRIVE_AMOUNT, 38'hFFFF);
        add_sample(make_item(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd32766);
        add_sample(make_item(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, -16'sd32767);
        add_sample(make_item(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd30);
        add_write(REG_MOD_ROUTING, route(SRC_LFO1, 16'hFFFF, SRC_ENV2, 16'hFFFF));
        add_sample(make_item(16'd20000, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000), 1'b0, 16'sd0);
        add_sample(make_item(16'd20000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF), 1'b0, 16'sd0);
        add_sample(make_item(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000), 1'b1, 16'sd0);
        add_write(REG_MOD_ROUTING, route(SRC_UNUSED_HI, 16'hFFFF, SRC_UNUSED_LO, 16'hFFFF));
        add_sample(make_item(-16'sd20000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1,
                   -16'sd32767);
        add_write(REG_MOD_ROUTING, route(SRC_LFO2, 16'h8000, SRC_ENV1, 16'h8000));
        add_sample(make_item(16'h1234, 16'h5555, 16'hAAAA, 16'hC3C3, 16'h3C3C), 1'b0, 16'sd0);
        add_write(REG_EFFECT_ENABLES, 38'd0);
        add_write(REG_MOD_ROUTING, route(SRC_NONE, 16'h0000, SRC_NONE, 16'h0000));
        add_write(REG_CRUSH_SHIFT, 38'd15);
        add_sample(make_item(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd0);
        add_sample(make_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, -16'sd32767);
        add_sample(make_item(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'sd0);
        add_write(REG_CRUSH_SHIFT, 38'd4);
        add_write(REG_XOR_MASK, 38'hFFFF);
        add_sample(make_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 16'sd0);
        add_sample(make_item(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 16'sd0);
        add_write(REG_XOR_MASK, 38'd0);
        add_write(REG_CRUSH_SHIFT, 38'd0);
        add_write(REG_EFFECT_ENABLES, 38'h7FF);
        add_write(REG_DELAY_TIME, 38'h3FFF);
        add_write(REG_DELAY_FEEDBACK, 38'hFFFF);
        add_write(REG_DRIVE_AMOUNT, 38'h8000);
        add_sample(make_item(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, 16'sd0);
        add_sample(make_item(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 16'sd0);
        add_write(REG_EFFECT_ENABLES, 38'd2);
        add_write(REG_DELAY_TIME, 38'd1);
        add_sample(make_item(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 16'sd0);
        add_sample(make_item(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0, 16'sd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        i = 0;
        while (i < script.size())
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                batch.delete();
                while (i < script.size() && script[i].kind == ROW_WRITE)
                begin
                    w.idx  = script[i].idx;
                    w.data = script[i].data;
                    batch.push_back(w);
                    i++;
                end
                apply_writes(batch);
            end
            else
            begin
                push_sample(script[i].item, script[i].typed, script[i].want);
                i++;
            end
        end

        while (sent < SAMPLE_GOAL)
        begin
            quiet     = (sent >= QUIET_FROM);
            idling_on = ($urandom_range(0, 3) != 0);
            batch.delete();
            for (int r = 0; r < 8; r++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    w.idx  = reg_idx_t'(r);
                    w.data = random_reg_value(w.idx);
                    batch.push_back(w);
                end
            end
            if (batch.size() == 0)
            begin
                w.idx  = REG_MASTER_VOLUME;
                w.data = random_reg_value(REG_MASTER_VOLUME);
                batch.push_back(w);
            end
            apply_writes(batch);
            n = $urandom_range(20, 120);
            repeat (n)
            begin
                s = make_item(pick16(), pick16(), pick16(), pick16(), pick16());
                push_sample(s, 1'b0, 16'sd0);
            end
        end

        sample_ch.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d samples through %0d configuration phases (%0d register writes).",
                 sent, phases, writes);
        $display("Compared %0d output samples, %0d with the delay line active, %0d errors.",
                 checked, echo_items, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/aec_pkg.sv
design/aec_sample_if.sv
design/aec_result_if.sv
design/aec_cfg_if.sv
design/aec_cfg_regs.sv
design/aec_delay_line.sv
design/aec_datapath.sv
design/audio_effects_chain.sv
test/tb_audio_effects_chain.sv
